// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, ante, cons, rst_n) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/tsie_pkg.sv -----
// Types and constants of the two-stack instruction executor.
package tsie_pkg;

    localparam int WORD_W = 32;

    typedef logic [WORD_W-1:0] word_t;

    // instruction characters
    localparam logic [7:0] OP_DIGIT0 = 8'h30;
    localparam logic [7:0] OP_DIGIT9 = 8'h39;
    localparam logic [7:0] OP_ZERO   = 8'h5F;
    localparam logic [7:0] OP_INC    = 8'h29;
    localparam logic [7:0] OP_DEC    = 8'h28;
    localparam logic [7:0] OP_ADD    = 8'h2B;
    localparam logic [7:0] OP_SUB    = 8'h2D;
    localparam logic [7:0] OP_MUL    = 8'h2A;
    localparam logic [7:0] OP_DIV    = 8'h2F;
    localparam logic [7:0] OP_REM    = 8'h25;
    localparam logic [7:0] OP_AND    = 8'h26;
    localparam logic [7:0] OP_OR     = 8'h7C;
    localparam logic [7:0] OP_XOR    = 8'h24;
    localparam logic [7:0] OP_NEG    = 8'h60;
    localparam logic [7:0] OP_NOT    = 8'h7E;
    localparam logic [7:0] OP_DUP    = 8'h3A;
    localparam logic [7:0] OP_DROP   = 8'h3B;
    localparam logic [7:0] OP_TO_AUX = 8'h7D;
    localparam logic [7:0] OP_TO_MAIN = 8'h7B;
    localparam logic [7:0] OP_SWAP   = 8'h3D;
    localparam logic [7:0] OP_DEPTH  = 8'h23;
    localparam logic [7:0] OP_READC  = 8'h2C;
    localparam logic [7:0] OP_READI  = 8'h3F;
    localparam logic [7:0] OP_PUTC   = 8'h2E;
    localparam logic [7:0] OP_PUTI   = 8'h21;
    localparam logic [7:0] OP_NEWLINE = 8'h5C;
    localparam logic [7:0] OP_HALT   = 8'h40;

    // write kinds
    localparam logic [1:0] WK_NONE    = 2'd0;
    localparam logic [1:0] WK_CHAR    = 2'd1;
    localparam logic [1:0] WK_INT     = 2'd2;
    localparam logic [1:0] WK_NEWLINE = 2'd3;

    // fault codes
    localparam logic [1:0] FLT_NONE     = 2'd0;
    localparam logic [1:0] FLT_DIV_ZERO = 2'd1;
    localparam logic [1:0] FLT_OVERFLOW = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- design/tsie_stack_ram.sv -----
// Single-port-write, single-port-read stack memory with registered read data.
module tsie_stack_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- design/tsie_divider.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module tsie_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  tsie_pkg::word_t       dividend,
    input  tsie_pkg::word_t       divisor,
    output tsie_pkg::word_t       quotient,
    output tsie_pkg::word_t       remainder,
    output tsie_pkg::div_status_t status
);

    localparam int W  = tsie_pkg::WORD_W;
    localparam int CW = $clog2(W);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    tsie_pkg::word_t quo_reg, quo_next;
    tsie_pkg::word_t rem_reg, rem_next;
    tsie_pkg::word_t div_reg, div_next;
    logic [W:0]      shifted;
    logic [W:0]      diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[W-1]};
        diff      = shifted - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- design/two_stack_instruction_executor.sv -----
// Top level of the two-stack instruction executor.
//
//  channel | direction | tdata fields, lowest bit first
//  --------+-----------+------------------------------------------------------------
//  s_      | in        | operation[7:0], read_value[39:8]
//  m_      | out       | write_kind, write_value, halted, fault, top_word, main_depth
//
// An item is taken in IDLE and executed in EXEC; '/' and '%' with a nonzero divisor
// go on through DIV and wait there for the one-bit-per-cycle divider. Both stacks
// keep their top word in a register and the rest in a memory whose read port always
// looks at the entry under the top. Reset clears state, counts, halt flag and output
// valid; memories need no clearing. A stalled result holds in the output register;
// the next item is still taken, and its execution waits until that register is free.
module two_stack_instruction_executor #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation[7:0], read_value[39:8]
    input  logic [39:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // write_kind[1:0], write_value[33:2], halted[34], fault[36:35],
    // top_word[68:37], main_depth above, zero fill to whole bytes
    output logic [((69+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int W      = tsie_pkg::WORD_W;
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int CW     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_B  = 69 + CW;
    localparam int OUT_W  = ((OUT_B + 7) / 8) * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [7:0]      op_reg;
    tsie_pkg::word_t rd_reg;
    logic [CW-1:0]   main_count_reg, main_count_next;
    logic [CW-1:0]   aux_count_reg, aux_count_next;
    tsie_pkg::word_t main_top_reg, main_top_next;
    tsie_pkg::word_t aux_top_reg, aux_top_next;
    logic            halt_reg, halt_next;

    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_kind_reg, out_kind_next;
    tsie_pkg::word_t out_value_reg, out_value_next;
    logic [1:0]      out_fault_reg, out_fault_next;
    tsie_pkg::word_t out_top_reg, out_top_next;

    logic            main_we, aux_we;
    logic [AW-1:0]   main_waddr, aux_waddr;
    tsie_pkg::word_t main_wdata, aux_wdata;
    tsie_pkg::word_t main_rdata, aux_rdata;

    tsie_pkg::word_t t0, s0, u0, v0;
    tsie_pkg::word_t mag_a, mag_b, quotient, remainder;
    tsie_pkg::div_status_t div_status;
    logic            div_start;
    logic            accept, out_free, commit, is_div;
    logic [CW-1:0]   m_rep1, m_rep2, m_pop;
    logic            main_full, aux_full;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign is_div   = (op_reg == tsie_pkg::OP_DIV) || (op_reg == tsie_pkg::OP_REM);

    // read the entry under each top; the read data is registered
    tsie_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(W)) u_main_ram (
        .aclk  (aclk),
        .we    (main_we),
        .waddr (main_waddr),
        .wdata (main_wdata),
        .raddr (AW'(main_count_reg - CW'(2))),
        .rdata (main_rdata)
    );

    tsie_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(W)) u_aux_ram (
        .aclk  (aclk),
        .we    (aux_we),
        .waddr (aux_waddr),
        .wdata (aux_wdata),
        .raddr (AW'(aux_count_reg - CW'(2))),
        .rdata (aux_rdata)
    );

    // empty slots read as zero
    assign t0 = (main_count_reg != '0)     ? main_top_reg : '0;
    assign s0 = (main_count_reg > CW'(1))  ? main_rdata   : '0;
    assign u0 = (aux_count_reg != '0)      ? aux_top_reg  : '0;
    assign v0 = (aux_count_reg > CW'(1))   ? aux_rdata    : '0;

    assign mag_a = s0[W-1] ? (-s0) : s0;
    assign mag_b = t0[W-1] ? (-t0) : t0;

    tsie_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (div_status)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!halt_reg && is_div && (t0 != '0)) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_status.done && !div_status.busy && out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // execute: pops and pushes against the cached tops
    always_comb begin
        m_rep1    = (main_count_reg == '0) ? CW'(1) : main_count_reg;
        m_rep2    = (main_count_reg > CW'(1)) ? (main_count_reg - CW'(1)) : CW'(1);
        m_pop     = (main_count_reg == '0) ? '0 : (main_count_reg - CW'(1));
        main_full = (main_count_reg == CW'(STACK_DEPTH));
        aux_full  = (aux_count_reg == CW'(STACK_DEPTH));

        main_count_next = main_count_reg;
        aux_count_next  = aux_count_reg;
        main_top_next   = main_top_reg;
        aux_top_next    = aux_top_reg;
        halt_next       = halt_reg;
        main_we         = 1'b0;
        aux_we          = 1'b0;
        main_waddr      = AW'(main_count_reg - CW'(1));
        aux_waddr       = AW'(aux_count_reg - CW'(1));
        main_wdata      = main_top_reg;
        aux_wdata       = aux_top_reg;
        out_kind_next   = tsie_pkg::WK_NONE;
        out_value_next  = '0;
        out_fault_next  = tsie_pkg::FLT_NONE;

        if (commit && !halt_reg) begin
            case (op_reg) inside
                [tsie_pkg::OP_DIGIT0:tsie_pkg::OP_DIGIT9]: begin
                    main_top_next   = (t0 << 3) + (t0 << 1) + W'(op_reg[3:0]);
                    main_count_next = m_rep1;
                end
                tsie_pkg::OP_INC: begin
                    main_top_next   = t0 + W'(1);
                    main_count_next = m_rep1;
                end
                tsie_pkg::OP_DEC: begin
                    main_top_next   = t0 - W'(1);
                    main_count_next = m_rep1;
                end
                tsie_pkg::OP_NEG: begin
                    main_top_next   = -t0;
                    main_count_next = m_rep1;
                end
                tsie_pkg::OP_NOT: begin
                    main_top_next   = ~t0;
                    main_count_next = m_rep1;
                end
                tsie_pkg::OP_ADD: begin
                    main_top_next   = s0 + t0;
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_SUB: begin
                    main_top_next   = s0 - t0;
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_MUL: begin
                    main_top_next   = W'(s0 * t0);
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_AND: begin
                    main_top_next   = s0 & t0;
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_OR: begin
                    main_top_next   = s0 | t0;
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_XOR: begin
                    main_top_next   = s0 ^ t0;
                    main_count_next = m_rep2;
                end
                tsie_pkg::OP_DIV, tsie_pkg::OP_REM: begin
                    if (t0 == '0) begin
                        out_fault_next = tsie_pkg::FLT_DIV_ZERO;
                    end else begin
                        if (op_reg == tsie_pkg::OP_DIV) begin
                            main_top_next = (s0[W-1] ^ t0[W-1]) ? (-quotient) : quotient;
                        end else begin
                            main_top_next = s0[W-1] ? (-remainder) : remainder;
                        end
                        main_count_next = m_rep2;
                    end
                end
                tsie_pkg::OP_ZERO, tsie_pkg::OP_DUP, tsie_pkg::OP_DEPTH,
                tsie_pkg::OP_READC, tsie_pkg::OP_READI, tsie_pkg::OP_TO_MAIN: begin
                    if (op_reg == tsie_pkg::OP_TO_MAIN) begin
                        // aux side pops even when the main push overflows
                        aux_count_next = (aux_count_reg == '0) ? '0
                                                               : (aux_count_reg - CW'(1));
                        aux_top_next   = v0;
                    end
                    if (main_full) begin
                        out_fault_next = tsie_pkg::FLT_OVERFLOW;
                    end else begin
                        main_we         = (main_count_reg != '0);
                        main_count_next = main_count_reg + CW'(1);
                        case (op_reg)
                            tsie_pkg::OP_ZERO:   main_top_next = '0;
                            tsie_pkg::OP_DUP:    main_top_next = t0;
                            tsie_pkg::OP_DEPTH:  main_top_next = W'(main_count_reg);
                            tsie_pkg::OP_TO_MAIN: main_top_next = u0;
                            default:             main_top_next = rd_reg;
                        endcase
                    end
                end
                tsie_pkg::OP_DROP, tsie_pkg::OP_PUTC, tsie_pkg::OP_PUTI,
                tsie_pkg::OP_TO_AUX: begin
                    main_count_next = m_pop;
                    main_top_next   = s0;
                    if (op_reg == tsie_pkg::OP_PUTC) begin
                        out_kind_next  = tsie_pkg::WK_CHAR;
                        out_value_next = W'(t0[7:0]);
                    end else if (op_reg == tsie_pkg::OP_PUTI) begin
                        out_kind_next  = tsie_pkg::WK_INT;
                        out_value_next = t0;
                    end else if (op_reg == tsie_pkg::OP_TO_AUX) begin
                        if (aux_full) begin
                            out_fault_next = tsie_pkg::FLT_OVERFLOW;
                        end else begin
                            aux_we         = (aux_count_reg != '0);
                            aux_count_next = aux_count_reg + CW'(1);
                            aux_top_next   = t0;
                        end
                    end
                end
                tsie_pkg::OP_SWAP: begin
                    main_top_next   = u0;
                    aux_top_next    = t0;
                    main_count_next = m_rep1;
                    aux_count_next  = (aux_count_reg == '0) ? CW'(1) : aux_count_reg;
                end
                tsie_pkg::OP_NEWLINE: begin
                    out_kind_next = tsie_pkg::WK_NEWLINE;
                end
                tsie_pkg::OP_HALT: begin
                    halt_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        out_top_next = (main_count_next != '0) ? main_top_next : '0;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            main_count_reg <= '0;
            aux_count_reg  <= '0;
            halt_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            main_count_reg <= main_count_next;
            aux_count_reg  <= aux_count_next;
            halt_reg       <= halt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload: tops, the latched beat and the result
    always_ff @(posedge aclk) begin
        main_top_reg <= main_top_next;
        aux_top_reg  <= aux_top_next;
        if (accept) begin
            op_reg <= s_tdata[7:0];
            rd_reg <= s_tdata[39:8];
        end
        if (commit) begin
            out_kind_reg  <= out_kind_next;
            out_value_reg <= out_value_next;
            out_fault_reg <= out_fault_next;
            out_top_reg   <= out_top_next;
        end
    end

    logic [CW-1:0] out_depth_reg;

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_depth_reg <= main_count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_B){1'b0}}, out_depth_reg, out_top_reg,
                       out_fault_reg, halt_reg, out_value_reg, out_kind_reg};

endmodule

// ----- design/tsie_checker.sv -----
// Port-level checker for the two-stack instruction executor, with its bind.
`include "assert_macros.svh"

module tsie_checker #(
    parameter int STACK_DEPTH = 256
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [((69+$clog2(STACK_DEPTH+1)+7)/8)*8-1:0] m_tdata
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // no write, no fault, halted set
    localparam logic [36:0] HALTED_QUIET = 37'h4_0000_0000;

    // a stalled beat stays up and holds its payload
    `ASSERT_NEXT(a_valid_holds, aclk, m_tvalid && !m_tready, m_tvalid, aresetn)
    `ASSERT_NEXT(a_data_holds, aclk, m_tvalid && !m_tready, $stable(m_tdata), aresetn)
    // no beat right after reset
    `ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid)
    // once halted, nothing is written and nothing faults
    `ASSERT_IMPLY(a_halt_quiet, aclk, aresetn, m_tvalid && m_tdata[34], m_tdata[36:0] == HALTED_QUIET)
    // depth never exceeds the stack size
    `ASSERT_IMPLY(a_depth_bound, aclk, aresetn, m_tvalid, m_tdata[69+CW-1:69] <= CW'(STACK_DEPTH))

endmodule

bind two_stack_instruction_executor tsie_checker #(.STACK_DEPTH(STACK_DEPTH)) u_tsie_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
